// ===== hdl/jsad_pkg.sv =====
// ----------------------------------------------------------------------------
// jsad_pkg
// Shared types, constants and microcode ROM for the arcade drive core.
// ----------------------------------------------------------------------------
`default_nettype none

package jsad_pkg;

   localparam int STICK_W    = 8;
   localparam int MAG_W      = 7;
   localparam int LEVEL_W    = 15;
   localparam int GAIN_W     = 9;
   localparam int TRIM_W     = 17;
   localparam int MUL_A_W    = 22;
   localparam int MUL_B_W    = 23;
   localparam int PROD_W     = 45;
   localparam int GOAL_LSB   = 29;
   localparam int DMAG_W     = 25;
   localparam int ACC_W      = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int PC_W       = 4;

   // ceil(2^29 / 127): floor(x * GOAL_RECIP / 2^29) == floor(x / 127) for x < 2^22
   localparam logic [MUL_B_W-1:0] GOAL_RECIP = 23'd4227331;
   localparam logic [MAG_W-1:0]   SAT_MAX    = 7'd127;

   // register reset values
   localparam logic [6:0]        RST_DEAD_ZONE  = 7'd25;
   localparam logic [6:0]        RST_RISE_STEP  = 7'd50;
   localparam logic [6:0]        RST_FALL_STEP  = 7'd50;
   localparam logic [GAIN_W-1:0] RST_TURN_GAIN  = 9'd179;
   localparam logic [TRIM_W-1:0] RST_RIGHT_TRIM = 17'd65210;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEAD_ZONE    = 3'd0,
      CSR_RISE_STEP    = 3'd1,
      CSR_FALL_STEP    = 3'd2,
      CSR_TURN_GAIN    = 3'd3,
      CSR_RIGHT_TRIM   = 3'd4,
      CSR_TURN_ASSIST  = 3'd5,
      CSR_REVERSE_MODE = 3'd6,
      CSR_CLIMB_MODE   = 3'd7
   } csr_idx_type;

   typedef enum logic [2:0] {
      MUL_NONE    = 3'd0,
      MUL_FSQ     = 3'd1,
      MUL_TSQ     = 3'd2,
      MUL_RECIP   = 3'd3,
      MUL_GAIN    = 3'd4,
      MUL_TRIM_LO = 3'd5,
      MUL_TRIM_HI = 3'd6
   } mul_sel_type;

   typedef enum logic [1:0] {
      SLEW_NONE = 2'd0,
      SLEW_FWD  = 2'd1,
      SLEW_TURN = 2'd2
   } slew_sel_type;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_MIX   = 3'd1,
      OP_ACC   = 3'd2,
      OP_RIGHT = 3'd3,
      OP_CLIMB = 3'd4
   } dp_op_type;

   typedef struct packed {
      mul_sel_type  mul_sel;
      slew_sel_type slew_sel;
      dp_op_type    op;
      logic         jmp_climb;
      logic         last;
   } ucode_word_type;

   typedef struct packed {
      logic           en;
      logic           done;
      ucode_word_type word;
   } ctrl_type;

   // program addresses
   localparam logic [PC_W-1:0] PC_F_SQ     = 4'd0;
   localparam logic [PC_W-1:0] PC_F_RECIP  = 4'd1;
   localparam logic [PC_W-1:0] PC_F_SLEW   = 4'd2;
   localparam logic [PC_W-1:0] PC_T_RECIP  = 4'd3;
   localparam logic [PC_W-1:0] PC_T_SLEW   = 4'd4;
   localparam logic [PC_W-1:0] PC_GAIN     = 4'd5;
   localparam logic [PC_W-1:0] PC_MIX      = 4'd6;
   localparam logic [PC_W-1:0] PC_TRIM_LO  = 4'd7;
   localparam logic [PC_W-1:0] PC_TRIM_HI  = 4'd8;
   localparam logic [PC_W-1:0] PC_RIGHT    = 4'd9;
   localparam logic [PC_W-1:0] PC_CLIMB    = 4'd10;

   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      w = '{mul_sel: MUL_NONE, slew_sel: SLEW_NONE, op: OP_NONE,
            jmp_climb: 1'b0, last: 1'b0};
      case (pc)
         PC_F_SQ:    w.mul_sel = MUL_FSQ;
         PC_F_RECIP: w.mul_sel = MUL_RECIP;
         PC_F_SLEW: begin
            w.slew_sel = SLEW_FWD;
            w.mul_sel  = MUL_TSQ;
         end
         PC_T_RECIP: w.mul_sel = MUL_RECIP;
         PC_T_SLEW: begin
            w.slew_sel  = SLEW_TURN;
            w.jmp_climb = 1'b1;
         end
         PC_GAIN:    w.mul_sel = MUL_GAIN;
         PC_MIX:     w.op = OP_MIX;
         PC_TRIM_LO: w.mul_sel = MUL_TRIM_LO;
         PC_TRIM_HI: begin
            w.mul_sel = MUL_TRIM_HI;
            w.op      = OP_ACC;
         end
         PC_RIGHT: begin
            w.op   = OP_RIGHT;
            w.last = 1'b1;
         end
         PC_CLIMB: begin
            w.op   = OP_CLIMB;
            w.last = 1'b1;
         end
         default:    w.last = 1'b1;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/joystick_slew_arcade_drive_core.sv =====
// ----------------------------------------------------------------------------
// joystick_slew_arcade_drive_core
// Arcade drive with deadzone, turn assist, squared response, slew limiting,
// turn gain, right-side trim and climb mode.
// ----------------------------------------------------------------------------
// Each request runs as one microcode program (shorter in climb mode) on the
//   single shared 22x23 multiplier; a new request is taken only once the
//   sequencer is idle again.
// A new request is taken while a finished response still waits; the last
//   program step then stalls until the response register is free.
// Reset: registers to defaults, slew levels to zero, sequencer idle, no response.
`default_nettype none

module joystick_slew_arcade_drive_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [jsad_pkg::STICK_W-1:0]  req_fwd_stick,
   input  wire logic signed [jsad_pkg::STICK_W-1:0]  req_side_stick,
   input  wire logic signed [jsad_pkg::STICK_W-1:0]  req_turn_stick,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [jsad_pkg::STICK_W-1:0]       rsp_left_drive,
   output logic signed [jsad_pkg::STICK_W-1:0]       rsp_right_drive,
   // register write port
   input  wire logic                                 csr_we,
   input  wire logic [jsad_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [jsad_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [6:0]                    dead_zone_ff,    dead_zone_in;
   logic [6:0]                    rise_step_ff,    rise_step_in;
   logic [6:0]                    fall_step_ff,    fall_step_in;
   logic [jsad_pkg::GAIN_W-1:0]   turn_gain_ff,    turn_gain_in;
   logic [jsad_pkg::TRIM_W-1:0]   right_trim_ff,   right_trim_in;
   logic                          turn_assist_ff,  turn_assist_in;
   logic                          reverse_mode_ff, reverse_mode_in;
   logic                          climb_mode_ff,   climb_mode_in;

   always_comb begin
      dead_zone_in    = dead_zone_ff;
      rise_step_in    = rise_step_ff;
      fall_step_in    = fall_step_ff;
      turn_gain_in    = turn_gain_ff;
      right_trim_in   = right_trim_ff;
      turn_assist_in  = turn_assist_ff;
      reverse_mode_in = reverse_mode_ff;
      climb_mode_in   = climb_mode_ff;
      if (csr_we) begin
         case (jsad_pkg::csr_idx_type'(csr_index))
            jsad_pkg::CSR_DEAD_ZONE:    dead_zone_in    = csr_wdata[6:0];
            jsad_pkg::CSR_RISE_STEP:    rise_step_in    = csr_wdata[6:0];
            jsad_pkg::CSR_FALL_STEP:    fall_step_in    = csr_wdata[6:0];
            jsad_pkg::CSR_TURN_GAIN:    turn_gain_in    = csr_wdata[jsad_pkg::GAIN_W-1:0];
            jsad_pkg::CSR_RIGHT_TRIM:   right_trim_in   = csr_wdata[jsad_pkg::TRIM_W-1:0];
            jsad_pkg::CSR_TURN_ASSIST:  turn_assist_in  = csr_wdata[0];
            jsad_pkg::CSR_REVERSE_MODE: reverse_mode_in = csr_wdata[0];
            jsad_pkg::CSR_CLIMB_MODE:   climb_mode_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff    <= jsad_pkg::RST_DEAD_ZONE;
         rise_step_ff    <= jsad_pkg::RST_RISE_STEP;
         fall_step_ff    <= jsad_pkg::RST_FALL_STEP;
         turn_gain_ff    <= jsad_pkg::RST_TURN_GAIN;
         right_trim_ff   <= jsad_pkg::RST_RIGHT_TRIM;
         turn_assist_ff  <= 1'b1;
         reverse_mode_ff <= 1'b0;
         climb_mode_ff   <= 1'b0;
      end else begin
         dead_zone_ff    <= dead_zone_in;
         rise_step_ff    <= rise_step_in;
         fall_step_ff    <= fall_step_in;
         turn_gain_ff    <= turn_gain_in;
         right_trim_ff   <= right_trim_in;
         turn_assist_ff  <= turn_assist_in;
         reverse_mode_ff <= reverse_mode_in;
         climb_mode_ff   <= climb_mode_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   logic                 start;
   logic                 busy;
   logic                 out_free;
   jsad_pkg::ctrl_type   ctrl;

   // ready only gates on the sequencer; a pending response does not block
   assign req_ready = !busy;
   assign start     = req_valid && req_ready;

   logic rsp_valid_ff, rsp_valid_in;
   assign out_free = !rsp_valid_ff || rsp_ready;

   jsad_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .climb    (climb_mode_ff),
      .out_free (out_free),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   logic signed [jsad_pkg::STICK_W-1:0] res_left, res_right;

   jsad_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .fwd_stick    (req_fwd_stick),
      .side_stick   (req_side_stick),
      .turn_stick   (req_turn_stick),
      .dead_zone    (dead_zone_ff),
      .rise_step    (rise_step_ff),
      .fall_step    (fall_step_ff),
      .turn_gain    (turn_gain_ff),
      .right_trim   (right_trim_ff),
      .turn_assist  (turn_assist_ff),
      .reverse_mode (reverse_mode_ff),
      .ctrl         (ctrl),
      .res_left     (res_left),
      .res_right    (res_right)
   );

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   logic signed [jsad_pkg::STICK_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [jsad_pkg::STICK_W-1:0] rsp_right_ff, rsp_right_in;

   always_comb begin
      rsp_valid_in = ctrl.done || (rsp_valid_ff && !rsp_ready);
      rsp_left_in  = ctrl.done ? res_left  : rsp_left_ff;
      rsp_right_in = ctrl.done ? res_right : rsp_right_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = rsp_left_ff;
   assign rsp_right_drive = rsp_right_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // an accepted request occupies the sequencer on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy && !req_ready))
      else $error("sequencer not busy after request accept");

   // the final step never overwrites a response still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.done |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten while pending");

   // a finished program always presents a response
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.done |=> rsp_valid)
      else $error("program finished without a response");

   // no microcode step runs while idle
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.en |-> busy)
      else $error("microcode step while idle");

endmodule

`default_nettype wire

// ===== hdl/jsad_useq.sv =====
// ----------------------------------------------------------------------------
// jsad_useq
// Microcode sequencer: step counter, control ROM, climb branch, output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module jsad_useq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               climb,
   input  wire logic               out_free,
   output logic                    busy,
   output jsad_pkg::ctrl_type      ctrl
);

   logic                          busy_ff, busy_in;
   logic [jsad_pkg::PC_W-1:0]     pc_ff, pc_in;
   jsad_pkg::ucode_word_type      word;
   logic                          step_en;

   assign word    = jsad_pkg::ucode_rom(pc_ff);
   // last step holds until the response slot is free
   assign step_en = busy_ff && !(word.last && !out_free);

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = jsad_pkg::PC_F_SQ;
      end else if (step_en) begin
         if (word.last) begin
            busy_in = 1'b0;
         end else if (word.jmp_climb && climb) begin
            pc_in = jsad_pkg::PC_CLIMB;
         end else begin
            pc_in = pc_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= jsad_pkg::PC_F_SQ;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy      = busy_ff;
   assign ctrl.en   = step_en;
   assign ctrl.done = step_en && word.last;
   assign ctrl.word = word;

endmodule

`default_nettype wire

// ===== hdl/jsad_datapath.sv =====
// ----------------------------------------------------------------------------
// jsad_datapath
// Stick conditioning, shared multiplier, slew limiter, mixer and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module jsad_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [jsad_pkg::STICK_W-1:0] fwd_stick,
   input  wire logic signed [jsad_pkg::STICK_W-1:0] side_stick,
   input  wire logic signed [jsad_pkg::STICK_W-1:0] turn_stick,
   input  wire logic [6:0]                          dead_zone,
   input  wire logic [6:0]                          rise_step,
   input  wire logic [6:0]                          fall_step,
   input  wire logic [jsad_pkg::GAIN_W-1:0]         turn_gain,
   input  wire logic [jsad_pkg::TRIM_W-1:0]         right_trim,
   input  wire logic                                turn_assist,
   input  wire logic                                reverse_mode,
   input  wire jsad_pkg::ctrl_type                  ctrl,
   output logic signed [jsad_pkg::STICK_W-1:0]      res_left,
   output logic signed [jsad_pkg::STICK_W-1:0]      res_right
);

   localparam int LW = jsad_pkg::LEVEL_W;
   localparam int MW = jsad_pkg::MAG_W;

   function automatic logic [7:0] mag8(input logic signed [7:0] v);
      return v[7] ? 8'(-v) : 8'(v);
   endfunction

   function automatic logic [MW-1:0] clamp7(input logic [7:0] m);
      return m[7] ? jsad_pkg::SAT_MAX : m[MW-1:0];
   endfunction

   function automatic logic [MW-1:0] sat7(input logic [10:0] m);
      return (m > 11'(jsad_pkg::SAT_MAX)) ? jsad_pkg::SAT_MAX : m[MW-1:0];
   endfunction

   function automatic logic signed [7:0] apply_sign(input logic [MW-1:0] m,
                                                    input logic neg);
      logic signed [7:0] p;
      p = $signed({1'b0, m});
      return neg ? -p : p;
   endfunction

   function automatic logic [LW-1:0] slew_next(input logic [LW-1:0] level,
                                               input logic [LW-1:0] goal,
                                               input logic [6:0]    rise,
                                               input logic [6:0]    fall);
      logic [LW-1:0] up, dn, diff, nxt;
      up = {rise, 8'b0};
      dn = {fall, 8'b0};
      if (goal > level) begin
         diff = goal - level;
         nxt  = (diff > up) ? level + up : goal;
      end else begin
         diff = level - goal;
         nxt  = (diff > dn) ? level - dn : goal;
      end
      return nxt;
   endfunction

   // captured stick magnitudes and signs
   logic [MW-1:0] fm_ff, fm_in, tm_ff, tm_in;
   logic          fneg_ff, fneg_in, fnz_ff, fnz_in;
   logic          tneg_ff, tneg_in, tnz_ff, tnz_in;

   // slew state
   logic [LW-1:0] fwd_level_ff, fwd_level_in, turn_level_ff, turn_level_in;

   // working registers
   logic [jsad_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic signed [7:0]                 left_ff, left_in;
   logic [jsad_pkg::DMAG_W-1:0]       dmag_ff, dmag_in;
   logic                              dneg_ff, dneg_in;
   logic [jsad_pkg::ACC_W-1:0]        acc_ff, acc_in;

   // stick conditioning
   logic [7:0] f_mag, s_mag, s_eff, t_mag, t_sel;
   logic       s_keep, s_neg, use_side, t_neg;

   always_comb begin
      f_mag    = mag8(fwd_stick);
      s_mag    = mag8(side_stick);
      t_mag    = mag8(turn_stick);
      s_keep   = s_mag >= {1'b0, dead_zone};
      s_eff    = s_keep ? s_mag : 8'd0;
      s_neg    = s_keep && side_stick[7];
      use_side = turn_assist && (t_mag < s_eff);
      t_sel    = use_side ? s_eff : t_mag;
      t_neg    = use_side ? s_neg : turn_stick[7];
      fm_in    = clamp7(f_mag);
      fneg_in  = fwd_stick[7];
      fnz_in   = |f_mag;
      tm_in    = clamp7(t_sel);
      tneg_in  = t_neg;
      tnz_in   = |t_sel;
   end

   // shared multiplier
   logic [jsad_pkg::MUL_A_W-1:0] mul_a;
   logic [jsad_pkg::MUL_B_W-1:0] mul_b;
   logic [jsad_pkg::PROD_W-1:0]  mul_p;

   always_comb begin
      case (ctrl.word.mul_sel)
         jsad_pkg::MUL_FSQ: begin
            mul_a = jsad_pkg::MUL_A_W'(fm_ff);
            mul_b = jsad_pkg::MUL_B_W'(fm_ff);
         end
         jsad_pkg::MUL_TSQ: begin
            mul_a = jsad_pkg::MUL_A_W'(tm_ff);
            mul_b = jsad_pkg::MUL_B_W'(tm_ff);
         end
         jsad_pkg::MUL_RECIP: begin
            mul_a = {prod_ff[13:0], 8'b0};
            mul_b = jsad_pkg::GOAL_RECIP;
         end
         jsad_pkg::MUL_GAIN: begin
            mul_a = jsad_pkg::MUL_A_W'(turn_level_ff);
            mul_b = jsad_pkg::MUL_B_W'(turn_gain);
         end
         jsad_pkg::MUL_TRIM_LO: begin
            mul_a = jsad_pkg::MUL_A_W'(dmag_ff[15:0]);
            mul_b = jsad_pkg::MUL_B_W'(right_trim);
         end
         jsad_pkg::MUL_TRIM_HI: begin
            mul_a = jsad_pkg::MUL_A_W'(dmag_ff[jsad_pkg::DMAG_W-1:16]);
            mul_b = jsad_pkg::MUL_B_W'(right_trim);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // slew limiter
   logic [LW-1:0] goal, slew_cur, slew_res;

   assign goal     = prod_ff[jsad_pkg::GOAL_LSB+LW-1:jsad_pkg::GOAL_LSB];
   assign slew_cur = (ctrl.word.slew_sel == jsad_pkg::SLEW_TURN) ? turn_level_ff
                                                                 : fwd_level_ff;
   assign slew_res = slew_next(slew_cur, goal, rise_step, fall_step);

   // mixer: F and T in Q16, sign-magnitude
   logic [25:0]        f_pos, t_pos, sum_mag, dif_mag;
   logic signed [25:0] f_s, t_s, sum_s, dif_s;
   logic               t_neg_eff;

   always_comb begin
      f_pos     = {3'b0, fwd_level_ff, 8'b0};
      t_pos     = {2'b0, prod_ff[23:0]};
      t_neg_eff = tneg_ff ^ reverse_mode;
      f_s       = !fnz_ff ? 26'sd0 : (fneg_ff ? -$signed(f_pos) : $signed(f_pos));
      t_s       = !tnz_ff ? 26'sd0 : (t_neg_eff ? -$signed(t_pos) : $signed(t_pos));
      sum_s     = f_s + t_s;
      dif_s     = f_s - t_s;
      sum_mag   = sum_s[25] ? 26'(-sum_s) : 26'(sum_s);
      dif_mag   = dif_s[25] ? 26'(-dif_s) : 26'(dif_s);
   end

   // right side: ((dh * trim) + ((dl * trim) >> 16)) >> 16
   logic [26:0] right_sum;
   logic signed [7:0] right_val, climb_val;

   assign right_sum = {1'b0, prod_ff[25:0]} + 27'(acc_ff);
   assign right_val = apply_sign(sat7(right_sum[26:16]), dneg_ff);
   assign climb_val = $signed({1'b0, fwd_level_ff[LW-1:8]});

   always_comb begin
      fwd_level_in  = fwd_level_ff;
      turn_level_in = turn_level_ff;
      prod_in       = prod_ff;
      left_in       = left_ff;
      dmag_in       = dmag_ff;
      dneg_in       = dneg_ff;
      acc_in        = acc_ff;
      if (ctrl.en) begin
         if (ctrl.word.slew_sel == jsad_pkg::SLEW_FWD) begin
            fwd_level_in = slew_res;
         end
         if (ctrl.word.slew_sel == jsad_pkg::SLEW_TURN) begin
            turn_level_in = slew_res;
         end
         if (ctrl.word.mul_sel != jsad_pkg::MUL_NONE) begin
            prod_in = mul_p;
         end
         if (ctrl.word.op == jsad_pkg::OP_MIX) begin
            left_in = apply_sign(sat7({2'b0, sum_mag[24:16]}), sum_s[25]);
            dmag_in = dif_mag[jsad_pkg::DMAG_W-1:0];
            dneg_in = dif_s[25];
         end
         if (ctrl.word.op == jsad_pkg::OP_ACC) begin
            acc_in = prod_ff[32:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_level_ff  <= '0;
         turn_level_ff <= '0;
      end else begin
         fwd_level_ff  <= fwd_level_in;
         turn_level_ff <= turn_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         fm_ff   <= fm_in;
         fneg_ff <= fneg_in;
         fnz_ff  <= fnz_in;
         tm_ff   <= tm_in;
         tneg_ff <= tneg_in;
         tnz_ff  <= tnz_in;
      end
      prod_ff <= prod_in;
      left_ff <= left_in;
      dmag_ff <= dmag_in;
      dneg_ff <= dneg_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      case (ctrl.word.op)
         jsad_pkg::OP_CLIMB: begin
            res_left  = climb_val;
            res_right = climb_val;
         end
         default: begin
            res_left  = left_ff;
            res_right = right_val;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== test/joystick_slew_arcade_drive_core_tb.sv =====
// ----------------------------------------------------------------------------
// joystick_slew_arcade_drive_core_tb
// Self-checking bench for the arcade drive core. Stick requests go in over a
// valid/ready channel and every accepted request is run through a local
// model of the drive math (deadzone, turn assist, squared response, slew
// limiting, gain, trim, reverse and climb). Each drive response is checked
// field by field, in order, against the predicted command.
// ----------------------------------------------------------------------------

module joystick_slew_arcade_drive_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STICK_W    = jsad_pkg::STICK_W;
   localparam int GAIN_W     = jsad_pkg::GAIN_W;
   localparam int TRIM_W     = jsad_pkg::TRIM_W;
   localparam int CSR_IDX_W  = jsad_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = jsad_pkg::CSR_DATA_W;

   // Quiet cycles (nothing accepted anywhere) before the run is declared hung.
   // Worst legit gap is the long receiver hold plus a request's own cycles.
   localparam int STALL_LIMIT = 2000;
   // Long receiver hold used to back the core up.
   localparam int HOLD_CYCLES = 150;
   // Settling time after the last response, well past the core's latency.
   localparam int TAIL_CYCLES = 30;
   localparam int DEFAULT_IDLE_PCT = 21;
   localparam int PHASE_ITEMS = 74;

   localparam longint Q16_ONE = 64'sd65536;
   localparam longint Q32_ONE = 64'sd4294967296;

   typedef struct packed {
      logic signed [STICK_W-1:0] left_cmd;
      logic signed [STICK_W-1:0] right_cmd;
   } drive_cmd_type;

   // ------------------------------------------------------------------------
   // Clock, reset and DUT hookup. All inputs start at known values.
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   logic signed [STICK_W-1:0] req_fwd_stick  = '0;
   logic signed [STICK_W-1:0] req_side_stick = '0;
   logic signed [STICK_W-1:0] req_turn_stick = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [STICK_W-1:0] rsp_left_drive;
   logic signed [STICK_W-1:0] rsp_right_drive;

   logic                      csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   joystick_slew_arcade_drive_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_fwd_stick   (req_fwd_stick),
      .req_side_stick  (req_side_stick),
      .req_turn_stick  (req_turn_stick),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Shadow registers and slew state, mirrored from the core's reset values.
   // ------------------------------------------------------------------------
   int cfg_dead_zone    = jsad_pkg::RST_DEAD_ZONE;
   int cfg_rise_step    = jsad_pkg::RST_RISE_STEP;
   int cfg_fall_step    = jsad_pkg::RST_FALL_STEP;
   int cfg_turn_gain    = jsad_pkg::RST_TURN_GAIN;
   int cfg_right_trim   = jsad_pkg::RST_RIGHT_TRIM;
   int cfg_turn_assist  = 1;
   int cfg_reverse_mode = 0;
   int cfg_climb_mode   = 0;

   // Q8 magnitudes, 0..32512
   int fwd_lvl  = 0;
   int turn_lvl = 0;

   drive_cmd_type drive_expected[$];

   int fail_count     = 0;
   int requests_sent  = 0;
   int responses_seen = 0;
   int settings_count = 1;

   // Idle odds per cycle on each side; zero gives a no-gap stretch.
   int req_idle_pct = DEFAULT_IDLE_PCT;
   int rsp_idle_pct = DEFAULT_IDLE_PCT;

   // Bumped by a test to ask the receiver for one long hold.
   int hold_seq = 0;

   // ------------------------------------------------------------------------
   // Drive math
   // ------------------------------------------------------------------------
   function automatic int axis_mag(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int axis_sign(input int v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   // Squared response: m*m/127 in Q8; -128 is treated as full scale.
   function automatic int squared_goal(input int v);
      int m;
      m = axis_mag(v);
      if (m > 127) m = 127;
      return (m * m * 256) / 127;
   endfunction

   // Move a level toward its goal, clipped by the rise/fall steps.
   function automatic int slew_level(input int lvl, input int goal);
      int err;
      err = goal - lvl;
      if (err > cfg_rise_step * 256) err = cfg_rise_step * 256;
      if (err < -cfg_fall_step * 256) err = -cfg_fall_step * 256;
      return lvl + err;
   endfunction

   function automatic longint clamp_drive(input longint v);
      if (v > 127) return 127;
      if (v < -127) return -127;
      return v;
   endfunction

   // Advances the slew state by one tick and returns the drive command.
   function automatic void predict_drive(input int fwd, input int side, input int turn,
                                         output drive_cmd_type cmd);
      longint f_term, t_term, l_val, r_val;
      if (axis_mag(side) < cfg_dead_zone) side = 0;
      // assist: a stronger left-stick x takes over turning (-128 counts as 128)
      if (cfg_turn_assist != 0 && axis_mag(turn) < axis_mag(side)) turn = side;

      fwd_lvl  = slew_level(fwd_lvl, squared_goal(fwd));
      turn_lvl = slew_level(turn_lvl, squared_goal(turn));

      if (cfg_climb_mode != 0) begin
         l_val = clamp_drive(fwd_lvl / 256);
         r_val = l_val;
      end else begin
         f_term = longint'(fwd_lvl) * 256 * axis_sign(fwd);
         t_term = longint'(cfg_turn_gain) * turn_lvl * axis_sign(turn);
         if (cfg_reverse_mode != 0) t_term = -t_term;
         // SV signed division truncates toward zero, as the core does
         l_val = clamp_drive((f_term + t_term) / Q16_ONE);
         r_val = clamp_drive(((f_term - t_term) * longint'(cfg_right_trim)) / Q32_ONE);
      end
      cmd.left_cmd  = l_val[STICK_W-1:0];
      cmd.right_cmd = r_val[STICK_W-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Stick value generation
   // ------------------------------------------------------------------------
   function automatic logic signed [STICK_W-1:0] rand_axis();
      logic signed [STICK_W-1:0] v;
      v = STICK_W'($urandom_range(255));
      if ($urandom_range(99) < 12) begin
         case ($urandom_range(5))
            0: v = -8'sd128;
            1: v = -8'sd127;
            2: v = 8'sd127;
            3: v = 8'sd1;
            4: v = -8'sd1;
            default: v = 8'sd0;
         endcase
      end
      return v;
   endfunction

   // Small wobble around a held stick position, kept in the 8-bit range.
   function automatic logic signed [STICK_W-1:0] nudge_axis(input logic signed [STICK_W-1:0] a);
      int v;
      v = int'(a) + int'($urandom_range(6)) - 3;
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return STICK_W'(v);
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Offers one request and predicts its response once it is taken.
   task automatic send_request(input logic signed [STICK_W-1:0] fwd,
                               input logic signed [STICK_W-1:0] side,
                               input logic signed [STICK_W-1:0] turn);
      drive_cmd_type cmd;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_fwd_stick  <= fwd;
      req_side_stick <= side;
      req_turn_stick <= turn;
      do @(posedge clock); while (!req_ready);
      predict_drive(fwd, side, turn, cmd);
      drive_expected.push_back(cmd);
      requests_sent++;
   endtask

   // Drops valid and waits until every predicted response has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (drive_expected.size() != 0);
   endtask

   task automatic write_csr(input jsad_pkg::csr_idx_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         jsad_pkg::CSR_DEAD_ZONE:    cfg_dead_zone    = value[6:0];
         jsad_pkg::CSR_RISE_STEP:    cfg_rise_step    = value[6:0];
         jsad_pkg::CSR_FALL_STEP:    cfg_fall_step    = value[6:0];
         jsad_pkg::CSR_TURN_GAIN:    cfg_turn_gain    = value[GAIN_W-1:0];
         jsad_pkg::CSR_RIGHT_TRIM:   cfg_right_trim   = value[TRIM_W-1:0];
         jsad_pkg::CSR_TURN_ASSIST:  cfg_turn_assist  = value[0];
         jsad_pkg::CSR_REVERSE_MODE: cfg_reverse_mode = value[0];
         jsad_pkg::CSR_CLIMB_MODE:   cfg_climb_mode   = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Full register load, only ever done with the core drained.
   task automatic load_config(input int dz, input int rise, input int fall, input int gain,
                              input int trim, input int assist, input int rev, input int climb);
      wait_idle();
      write_csr(jsad_pkg::CSR_DEAD_ZONE, dz);
      write_csr(jsad_pkg::CSR_RISE_STEP, rise);
      write_csr(jsad_pkg::CSR_FALL_STEP, fall);
      write_csr(jsad_pkg::CSR_TURN_GAIN, gain);
      write_csr(jsad_pkg::CSR_RIGHT_TRIM, trim);
      write_csr(jsad_pkg::CSR_TURN_ASSIST, assist);
      write_csr(jsad_pkg::CSR_REVERSE_MODE, rev);
      write_csr(jsad_pkg::CSR_CLIMB_MODE, climb);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   task automatic load_random_config();
      int gain, trim;
      gain = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(256);
      trim = ($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(60000, 66000);
      load_config($urandom_range(127), $urandom_range(127), $urandom_range(127), gain, trim,
                  $urandom_range(1), $urandom_range(1), ($urandom_range(4) == 0));
   endtask

   // ------------------------------------------------------------------------
   // Response side: random ready, one long hold on request, in-order check.
   // ------------------------------------------------------------------------
   task automatic check_drive_response(input logic signed [STICK_W-1:0] left_got,
                                       input logic signed [STICK_W-1:0] right_got);
      drive_cmd_type want;
      responses_seen++;
      if (drive_expected.size() == 0) begin
         $display("[%0t] unexpected response: left %0d right %0d",
                  $time, left_got, right_got);
         fail_count++;
      end else begin
         want = drive_expected.pop_front();
         if (left_got !== want.left_cmd) begin
            $display("[%0t] left_drive mismatch: expected %0d actual %0d",
                     $time, want.left_cmd, left_got);
            fail_count++;
         end
         if (right_got !== want.right_cmd) begin
            $display("[%0t] right_drive mismatch: expected %0d actual %0d",
                     $time, want.right_cmd, right_got);
            fail_count++;
         end
      end
   endtask

   int hold_seen = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      // values sampled here are the ones from just before this edge
      if (!reset && rsp_valid && rsp_ready)
         check_drive_response(rsp_left_drive, rsp_right_drive);
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Hang detector: any accepted request, response or register write resets it.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[%0t] timeout: nothing moved for %0d cycles, %0d responses outstanding",
               $time, STALL_LIMIT, drive_expected.size());
      $display("joystick_slew_arcade_drive_core verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset defaults: full-scale ramps, -128 handling, deadzone edge, assist.
   task automatic test_directed_extremes();
      repeat (3) send_request(8'sd127, 8'sd0, 8'sd0);   // climbs 50 units per tick
      send_request(-8'sd128, 8'sd0, 8'sd0);             // -128: full scale, negative
      send_request(-8'sd127, 8'sd0, 8'sd0);
      send_request(8'sd0, 8'sd0, 8'sd0);                // falls toward zero
      send_request(8'sd0, 8'sd0, 8'sd127);
      send_request(8'sd0, 8'sd0, -8'sd128);
      send_request(8'sd0, 8'sd24, 8'sd0);               // just inside deadzone
      send_request(8'sd0, 8'sd25, 8'sd0);               // at deadzone, assist takes it
      send_request(8'sd0, -8'sd128, 8'sd127);           // side counts as 128, wins
      send_request(8'sd0, 8'sd127, -8'sd128);           // turn counts as 128, keeps it
      send_request(8'sd127, 8'sd127, 8'sd127);          // saturates
      send_request(-8'sd128, -8'sd128, -8'sd128);
   endtask

   // Frozen slew, reverse, oversized gain/trim, full deadzone, assist off, climb mode.
   task automatic test_special_cases();
      load_config(0, 0, 0, 256, 65536, 0, 1, 0);
      send_request(8'sd0, 8'sd0, 8'sd0);                // levels hold against goal
      send_request(8'sd127, 8'sd0, -8'sd127);
      send_request(-8'sd127, 8'sd5, 8'sd5);
      load_config(127, 127, 127, 511, 131071, 1, 0, 0);
      send_request(8'sd127, -8'sd128, 8'sd0);           // only magnitude 127 or 128 clears deadzone
      send_request(-8'sd127, 8'sd126, 8'sd3);
      send_request(8'sd127, 8'sd0, 8'sd127);
      load_config(jsad_pkg::RST_DEAD_ZONE, jsad_pkg::RST_RISE_STEP, jsad_pkg::RST_FALL_STEP,
                  jsad_pkg::RST_TURN_GAIN, jsad_pkg::RST_RIGHT_TRIM, 1, 0, 1);
      send_request(8'sd127, 8'sd0, 8'sd0);
      send_request(-8'sd128, 8'sd0, 8'sd127);           // climb ignores sign and turn
      send_request(-8'sd64, 8'sd0, 8'sd0);
      send_request(8'sd0, 8'sd0, 8'sd0);
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so the
   // core fills and pushes back on req_ready.
   task automatic test_backpressure();
      load_config(jsad_pkg::RST_DEAD_ZONE, jsad_pkg::RST_RISE_STEP, jsad_pkg::RST_FALL_STEP,
                  jsad_pkg::RST_TURN_GAIN, jsad_pkg::RST_RIGHT_TRIM, 1, 0, 0);
      req_idle_pct = 0;
      hold_seq++;
      repeat (16) send_request(rand_axis(), rand_axis(), rand_axis());
      req_idle_pct = DEFAULT_IDLE_PCT;
   endtask

   // One request at a time, each after the previous response is back.
   task automatic test_paced_requests();
      load_random_config();
      repeat (20) begin
         wait_idle();
         send_request(rand_axis(), rand_axis(), rand_axis());
      end
   endtask

   // Mostly held stick positions with a little wobble so the slew levels
   // ramp all the way, mixed with single random requests as noise.
   task automatic run_random_phase(input int n_items);
      int sent, run_len;
      logic signed [STICK_W-1:0] f, s, t;
      sent = 0;
      while (sent < n_items) begin
         f = rand_axis();
         s = rand_axis();
         t = rand_axis();
         run_len = ($urandom_range(9) < 7) ? $urandom_range(2, 8) : 1;
         repeat (run_len) begin
            send_request(f, s, t);
            sent++;
            if ($urandom_range(1) == 0) begin
               f = nudge_axis(f);
               s = nudge_axis(s);
               t = nudge_axis(t);
            end
         end
      end
   endtask

   task automatic test_random_sweep();
      load_config(0, 127, 127, 0, 0, 0, 0, 0);
      run_random_phase(PHASE_ITEMS);
      load_config(127, 1, 1, 256, 65536, 1, 1, 0);
      run_random_phase(PHASE_ITEMS);
      // stretch with no gaps on either side
      load_config(jsad_pkg::RST_DEAD_ZONE, jsad_pkg::RST_RISE_STEP, jsad_pkg::RST_FALL_STEP,
                  jsad_pkg::RST_TURN_GAIN, jsad_pkg::RST_RIGHT_TRIM, 1, 0, 1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random_phase(PHASE_ITEMS);
      load_config(0, 0, 127, 511, 131071, 1, 1, 0);
      req_idle_pct = DEFAULT_IDLE_PCT;
      rsp_idle_pct = DEFAULT_IDLE_PCT;
      run_random_phase(PHASE_ITEMS);
      load_config(10, 127, 0, 179, 65210, 0, 0, 0);
      run_random_phase(PHASE_ITEMS);
      repeat (3) begin
         load_random_config();
         run_random_phase(PHASE_ITEMS);
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_special_cases();
      test_backpressure();
      test_paced_requests();
      test_random_sweep();

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests / %0d responses over %0d register settings,",
               requests_sent, responses_seen, settings_count);
      $display("incl. climb, reverse, frozen slew, oversized gain/trim and long backpressure.");
      if (fail_count == 0 && drive_expected.size() == 0) begin
         $display("joystick_slew_arcade_drive_core verification clean");
      end else begin
         $display("joystick_slew_arcade_drive_core verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/jsad_pkg.sv
hdl/jsad_useq.sv
hdl/jsad_datapath.sv
hdl/joystick_slew_arcade_drive_core.sv
test/joystick_slew_arcade_drive_core_tb.sv
